// File: sv/kped_pkg.sv
// types and constants shared by the key press event detector
package kped_pkg;

    localparam int unsigned NOW_W       = 16;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned LPT_W       = 6;
    localparam int unsigned LPT_MS_W    = 13;

    localparam int unsigned DEBOUNCE_MS = 50;
    localparam int unsigned REPEAT_MS   = 300;
    localparam int unsigned SWITCH_MS   = 100;
    localparam int unsigned LPT_UNIT_MS = 100;

    localparam logic [LPT_W-1:0] LPT_DEFAULT = 6'd10;
    localparam logic [LPT_W-1:0] LPT_MIN     = 6'd4;
    localparam logic [LPT_W-1:0] LPT_MAX     = 6'd50;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_UNLOCKED        = 3'd0,
        REG_INPUT_MODE      = 3'd1,
        REG_FEEDBACK_ENABLE = 3'd2,
        REG_ACTIVE_LOW      = 3'd3,
        REG_LONG_PRESS_TIME = 3'd4,
        REG_CHANNEL_NUMBER  = 3'd5
    } kped_reg_t;

    typedef struct packed {
        logic             pin_level;
        logic [NOW_W-1:0] now_ms;
        logic             bus_busy;
    } kped_poll_t;

    typedef struct packed {
        logic       event_valid;
        logic [7:0] event_channel;
        logic [7:0] event_count;
        logic       event_long;
        logic       feedback_valid;
        logic       feedback_on;
    } kped_result_t;

    typedef struct packed {
        logic             unlocked;
        logic             input_mode;
        logic             feedback_enable;
        logic             active_low;
        logic [LPT_W-1:0] long_press_time;
        logic [7:0]       channel_number;
    } kped_cfg_t;

    typedef struct packed {
        logic       press_seen;
        logic       long_seen;
        logic [7:0] press_count;
    } kped_flags_t;

    localparam kped_cfg_t CFG_RESET = '{
        unlocked:        1'b1,
        input_mode:      1'b0,
        feedback_enable: 1'b0,
        active_low:      1'b1,
        long_press_time: LPT_DEFAULT,
        channel_number:  8'd0
    };

endpackage

// File: sv/kped_poll_if.sv
// valid/ready channel carrying one poll item
interface kped_poll_if;
    import kped_pkg::*;

    logic       valid;
    logic       ready;
    kped_poll_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/kped_event_if.sv
// valid/ready channel carrying one result item
interface kped_event_if;
    import kped_pkg::*;

    logic         valid;
    logic         ready;
    kped_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/key_press_event_detector_unit.sv
// top level of the debounced key and long press event detector
//
// one poll item in, one result item out, sustained rate of one item per clock
// while key_event.ready stays high. an item lands in the input register, and
// the decision logic (a few wrapping time subtractions, compares and an 8-bit
// count increment) writes the channel state and the result register as the item
// moves on. the result register is the only place a finished item waits, so
// a new poll is taken whenever the result register is empty or being drained
// in the same cycle. configuration writes are registered; any write to a
// known register clears the press state and the counter, a long press time
// whose low six bits fall outside 4..50 is stored as 10, and writes to
// unknown indexes are dropped. TIME_BITS sets the width of the stored press
// and long press timestamps and thus the wrap of all elapsed time figures.
module key_press_event_detector_unit #(
    parameter int unsigned TIME_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [kped_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [kped_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    kped_poll_if.sink                            poll,
    kped_event_if.source                         key_event
);
    import kped_pkg::*;

    // configuration and channel state
    kped_cfg_t            cfg_reg;
    kped_cfg_t            cfg_next;
    logic                 cfg_hit;
    kped_flags_t          flags_reg;
    kped_flags_t          flags_next;
    logic [TIME_BITS-1:0] press_time_reg;
    logic [TIME_BITS-1:0] press_time_next;
    logic [TIME_BITS-1:0] long_time_reg;
    logic [TIME_BITS-1:0] long_time_next;

    // pipeline
    kped_poll_t           poll_reg;
    logic                 poll_vld_reg;
    kped_result_t         res_reg;
    kped_result_t         res_next;
    logic                 res_vld_reg;
    logic                 advance;

    logic [LPT_W-1:0]     lpt_wr;

    // the held poll moves on when the result register is free or draining
    assign advance    = poll_vld_reg && (!res_vld_reg || key_event.ready);
    assign poll.ready = !poll_vld_reg || advance;

    assign key_event.valid = res_vld_reg;
    assign key_event.data  = res_reg;

    // register write decode
    assign lpt_wr = cfg_wdata[LPT_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        cfg_hit  = 1'b1;
        case (kped_reg_t'(cfg_index))
            REG_UNLOCKED:        cfg_next.unlocked        = cfg_wdata[0];
            REG_INPUT_MODE:      cfg_next.input_mode      = cfg_wdata[0];
            REG_FEEDBACK_ENABLE: cfg_next.feedback_enable = cfg_wdata[0];
            REG_ACTIVE_LOW:      cfg_next.active_low      = cfg_wdata[0];
            REG_LONG_PRESS_TIME:
                // out of range thresholds fall back to the default
                cfg_next.long_press_time =
                    (lpt_wr inside {[LPT_MIN:LPT_MAX]}) ? lpt_wr : LPT_DEFAULT;
            REG_CHANNEL_NUMBER:  cfg_next.channel_number  = cfg_wdata[7:0];
            default:             cfg_hit = 1'b0;
        endcase
    end

    kped_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .cfg             (cfg_reg),
        .flags           (flags_reg),
        .press_time      (press_time_reg),
        .long_time       (long_time_reg),
        .item            (poll_reg),
        .flags_next      (flags_next),
        .press_time_next (press_time_next),
        .long_time_next  (long_time_next),
        .res             (res_next)
    );

    // config and state; a config write wipes the press history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= CFG_RESET;
            flags_reg      <= '0;
            press_time_reg <= '0;
            long_time_reg  <= '0;
        end
        else if (cfg_wr_en && cfg_hit)
        begin
            cfg_reg        <= cfg_next;
            flags_reg      <= '0;
            press_time_reg <= '0;
            long_time_reg  <= '0;
        end
        else if (advance)
        begin
            flags_reg      <= flags_next;
            press_time_reg <= press_time_next;
            long_time_reg  <= long_time_next;
        end
    end

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (poll.ready)
            begin
                poll_vld_reg <= poll.valid;
            end
            if (advance)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (key_event.ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            poll_reg <= poll.data;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // counter only moves when a poll is processed or a register is written
    a_count_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && !cfg_wr_en) |=> $stable(flags_reg.press_count))
        else $error("press counter changed without a poll or config write");

    // a locked channel yields an all-zero result
    a_locked_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg_reg.unlocked) |=> (res_vld_reg && res_reg == '0))
        else $error("locked channel produced a non-empty result");

    // qualifier bits never stand without their valid bits
    a_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg |-> ((!res_reg.feedback_on || res_reg.feedback_valid)
                         && (!res_reg.event_long || res_reg.event_valid)))
        else $error("result qualifier set without its valid bit");

endmodule

// File: sv/kped_step.sv
// per-poll decision logic: next state and result item from one poll
module kped_step #(
    parameter int unsigned TIME_BITS = 16
) (
    input  kped_pkg::kped_cfg_t    cfg,
    input  kped_pkg::kped_flags_t  flags,
    input  logic [TIME_BITS-1:0]   press_time,
    input  logic [TIME_BITS-1:0]   long_time,
    input  kped_pkg::kped_poll_t   item,
    output kped_pkg::kped_flags_t  flags_next,
    output logic [TIME_BITS-1:0]   press_time_next,
    output logic [TIME_BITS-1:0]   long_time_next,
    output kped_pkg::kped_result_t res
);
    import kped_pkg::*;

    localparam int unsigned NB = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] el_press;
    logic [TIME_BITS-1:0] el_long;
    logic [LPT_MS_W-1:0]  lpt_ms;
    logic [7:0]           count_inc;
    logic                 pressed;
    logic                 ev;
    logic                 ev_long;
    logic                 fb;
    logic                 fb_on;
    logic [7:0]           ev_count;

    always_comb
    begin
        now_t = '0;
        now_t[NB-1:0] = item.now_ms[NB-1:0];
    end

    // differences wrap at the time width
    assign el_press  = now_t - press_time;
    assign el_long   = now_t - long_time;
    assign lpt_ms    = LPT_MS_W'(cfg.long_press_time) * LPT_MS_W'(LPT_UNIT_MS);
    assign count_inc = flags.press_count + 8'd1;
    assign pressed   = item.pin_level ^ cfg.active_low;

    always_comb
    begin
        flags_next      = flags;
        press_time_next = press_time;
        long_time_next  = long_time;
        ev              = 1'b0;
        ev_long         = 1'b0;
        ev_count        = '0;
        fb              = 1'b0;
        fb_on           = 1'b0;

        if (cfg.unlocked)
        begin
            if (!cfg.input_mode)
            begin
                // push button
                if (!pressed)
                begin
                    if (flags.press_seen)
                    begin
                        if (el_press >= TIME_BITS'(DEBOUNCE_MS) && !flags.long_seen)
                        begin
                            flags_next.press_count = count_inc;
                            ev       = 1'b1;
                            ev_count = count_inc;
                        end
                        flags_next.press_seen = 1'b0;
                        fb = 1'b1;
                    end
                end
                else if (flags.press_seen)
                begin
                    if (flags.long_seen)
                    begin
                        // repeat of a long press
                        if (el_long >= TIME_BITS'(REPEAT_MS))
                        begin
                            long_time_next = now_t;
                            ev       = 1'b1;
                            ev_long  = 1'b1;
                            ev_count = flags.press_count;
                        end
                    end
                    else if (el_press >= TIME_BITS'(lpt_ms))
                    begin
                        flags_next.press_count = count_inc;
                        flags_next.long_seen   = 1'b1;
                        long_time_next = now_t;
                        ev       = 1'b1;
                        ev_long  = 1'b1;
                        ev_count = count_inc;
                    end
                end
                else
                begin
                    flags_next.press_seen = 1'b1;
                    flags_next.long_seen  = 1'b0;
                    press_time_next = now_t;
                    fb    = 1'b1;
                    fb_on = 1'b1;
                end
            end
            else
            begin
                // switch
                if (!pressed)
                begin
                    if (flags.long_seen && !item.bus_busy)
                    begin
                        ev       = 1'b1;
                        ev_count = flags.press_count;
                        flags_next.press_count = count_inc;
                        flags_next.long_seen   = 1'b0;
                    end
                    flags_next.press_seen = 1'b0;
                    fb = 1'b1;
                end
                else
                begin
                    if (!flags.press_seen)
                    begin
                        flags_next.press_seen = 1'b1;
                        press_time_next = now_t;
                    end
                    else if (el_press >= TIME_BITS'(SWITCH_MS) && !flags.long_seen
                             && !item.bus_busy)
                    begin
                        ev       = 1'b1;
                        ev_count = flags.press_count;
                        flags_next.press_count = count_inc;
                        flags_next.long_seen   = 1'b1;
                        long_time_next = now_t;
                    end
                    fb    = 1'b1;
                    fb_on = 1'b1;
                end
            end

            if (!cfg.feedback_enable)
            begin
                fb    = 1'b0;
                fb_on = 1'b0;
            end
        end

        res.event_valid    = ev;
        res.event_channel  = ev ? cfg.channel_number : 8'd0;
        res.event_count    = ev ? ev_count : 8'd0;
        res.event_long     = ev & ev_long;
        res.feedback_valid = fb;
        res.feedback_on    = fb & fb_on;
    end

endmodule
